// ===== sv/pssl_pkg.sv =====
package pssl_pkg;

    // Field widths of one load request.
    localparam int unsigned REF_DIV_W = 14;
    localparam int unsigned MAIN_W    = 11;
    localparam int unsigned SWALLOW_W = 7;

    // The divider word is the longest: 11 + 7 + 1 control bit.
    localparam int unsigned WORD_W = 19;

    // Beats per word, including the closing latch-enable beat.
    localparam int unsigned ITEM_CNT_W = 5;
    localparam logic [ITEM_CNT_W-1:0] REF_ITEMS = 5'd17;
    localparam logic [ITEM_CNT_W-1:0] DIV_ITEMS = 5'd20;
    localparam logic [ITEM_CNT_W-1:0] LATCH_ITEM = 5'd1;

    // Request codes.
    localparam logic OP_REF = 1'b0;
    localparam logic OP_DIV = 1'b1;

    // Strobe kinds.
    localparam logic STROBE_CLOCK = 1'b0;
    localparam logic STROBE_LATCH = 1'b1;

    // Control bits that close each word.
    localparam logic CTRL_REF = 1'b1;
    localparam logic CTRL_DIV = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_SEND
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
    } t_shift_ctrl;

    typedef struct packed {
        logic data_bit;
        logic latch;
    } t_shift_stat;

endpackage

// ===== sv/pssl_timer.sv =====
module pssl_timer import pssl_pkg::*; #(
    parameter int unsigned HALF_WAIT = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_done
);

    // Four half-waits per strobe period.
    localparam int unsigned WAIT_CYCLES = 4 * HALF_WAIT;
    localparam int unsigned CW = $clog2(WAIT_CYCLES);
    localparam logic [CW-1:0] LOAD_VAL = CW'(WAIT_CYCLES - 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_busy,  n_busy;

    assign o_done = r_busy && (r_count == '0);

    always_comb begin
        n_count = r_count;
        n_busy  = r_busy;
        if (i_start) begin
            n_count = LOAD_VAL;
            n_busy  = 1'b1;
        end else if (o_done) begin
            n_busy = 1'b0;
        end else if (r_busy) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_count <= n_count;
    end

endmodule

// ===== sv/pssl_shifter.sv =====
module pssl_shifter import pssl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_shift_ctrl          i_ctrl,
    input  logic                 i_op,
    input  logic                 i_prescaler_bit,
    input  logic [REF_DIV_W-1:0] i_divide_value,
    input  logic [SWALLOW_W-1:0] i_swallow_count,
    output t_shift_stat          o_stat
);

    logic [WORD_W-1:0]     r_word, n_word;
    logic [ITEM_CNT_W-1:0] r_left, n_left;

    // The word is left aligned so the next bit out is always the top bit.
    always_comb begin
        n_word = r_word;
        n_left = r_left;
        if (i_ctrl.load) begin
            if (i_op == OP_REF) begin
                n_word = {i_prescaler_bit, i_divide_value, CTRL_REF, 3'b000};
                n_left = REF_ITEMS;
            end else begin
                n_word = {i_divide_value[MAIN_W-1:0], i_swallow_count, CTRL_DIV};
                n_left = DIV_ITEMS;
            end
        end else if (i_ctrl.advance) begin
            n_word = {r_word[WORD_W-2:0], 1'b0};
            n_left = r_left - 1'b1;
        end
    end

    assign o_stat.latch    = (r_left == LATCH_ITEM);
    assign o_stat.data_bit = o_stat.latch ? 1'b0 : r_word[WORD_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
        r_word <= n_word;
    end

endmodule

// ===== sv/pll_synth_serial_loader.sv =====
// Serial loader for a three-wire PLL synthesizer interface.
// The input channel (i_valid / o_ready) takes one load request per beat:
// op 0 loads the reference word (prescaler bit, 14-bit reference divider,
// control bit 1), op 1 loads the divider word (11-bit main counter, 7-bit
// swallow count, control bit 0). Unused upper bits are dropped.
// The output channel (o_valid / i_ready) sends one beat per clock strobe,
// data bit first out MSB first, then one latch-enable beat with o_last set.
// A reference request gives 17 beats, a divider request 20 beats.
// Each beat is preceded by a strobe period counted by one shared down
// counter, which starts when the previous beat or the request is taken;
// the beat is raised once that period has run out.
// Only one request is in flight at a time.
// If the receiver stalls, the offered beat holds and the sequencer waits;
// the strobe period of the next beat starts when the stalled one is taken.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any word in progress; no beat is offered until a new request arrives.
module pll_synth_serial_loader import pssl_pkg::*; #(
    parameter int unsigned HALF_WAIT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_op,
    input  logic                 i_prescaler_bit,
    input  logic [REF_DIV_W-1:0] i_divide_value,
    input  logic [SWALLOW_W-1:0] i_swallow_count,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_data_bit,
    output logic                 o_strobe_kind,
    output logic                 o_last
);

    t_state      r_state, n_state;
    t_shift_ctrl shift_ctrl;
    t_shift_stat shift_stat;
    logic        timer_start;
    logic        timer_done;
    logic        in_beat;
    logic        out_beat;

    assign in_beat  = i_valid && o_ready;
    assign out_beat = o_valid && i_ready;

    pssl_timer #(
        .HALF_WAIT (HALF_WAIT)
    ) u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (timer_start),
        .o_done  (timer_done)
    );

    pssl_shifter u_shifter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (shift_ctrl),
        .i_op            (i_op),
        .i_prescaler_bit (i_prescaler_bit),
        .i_divide_value  (i_divide_value),
        .i_swallow_count (i_swallow_count),
        .o_stat          (shift_stat)
    );

    // Next state: idle until a request, wait out the strobe period, then
    // hold the beat until it is taken.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (timer_done) begin
                    n_state = S_SEND;
                end
            end
            S_SEND: begin
                if (i_ready) begin
                    n_state = shift_stat.latch ? S_IDLE : S_WAIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_ready            = 1'b0;
        o_valid            = 1'b0;
        shift_ctrl.load    = 1'b0;
        shift_ctrl.advance = 1'b0;
        timer_start        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready         = 1'b1;
                shift_ctrl.load = i_valid;
                timer_start     = i_valid;
            end
            S_WAIT: begin
            end
            S_SEND: begin
                o_valid            = 1'b1;
                shift_ctrl.advance = i_ready;
                timer_start        = i_ready && !shift_stat.latch;
            end
            default: begin
            end
        endcase
    end

    assign o_data_bit    = shift_stat.data_bit;
    assign o_strobe_kind = shift_stat.latch ? STROBE_LATCH : STROBE_CLOCK;
    assign o_last        = shift_stat.latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // A request closes the input side until its word is done.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_ready)
        else $error("input taken while a word is in progress");

    // The latch beat ends the word and the block is ready right after.
    a_idle_after_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_last) |=> o_ready)
        else $error("not ready after the latch beat");

    // A clock beat is followed by a full strobe period before the next beat.
    a_gap_after_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && !o_last) |=> !o_valid)
        else $error("beat offered without a strobe period");

    // The input and output sides are never open together.
    a_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready and valid both raised");

    // A latch beat always carries a low data level.
    a_latch_data_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_strobe_kind == STROBE_LATCH) |-> (!o_data_bit && o_last))
        else $error("latch beat carries data");
`endif

endmodule
